FILE: design/tqr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tqr_pkg;

  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_SERVICE   = 2'd1,
    OP_MOVE_UP   = 2'd2,
    OP_MOVE_DOWN = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY_TEXT  = 3'd1,
    ST_FULL        = 3'd2,
    ST_IDS_OUT     = 3'd3,
    ST_QUEUE_EMPTY = 3'd4,
    ST_BAD_POS     = 3'd5
  } status_t;

  // what the cells of the row do when a command is accepted
  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_SHIFT,
    ACT_SWAP_UP,
    ACT_SWAP_DOWN
  } act_t;

  localparam int ID_W  = 16;
  localparam int REF_W = 32;
  localparam int POS_W = 8;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [REF_W-1:0] customer;
    logic [REF_W-1:0] complaint;
  } entry_t;

  typedef struct packed {
    act_t             act;
    logic [POS_W-1:0] index;
    entry_t           load;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: design/tqr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module tqr_cell #(
  parameter int IDX = 0
) (
  input  wire              clk,
  input  tqr_pkg::cell_cmd_t cmd,
  input  tqr_pkg::entry_t  prev_entry,
  input  tqr_pkg::entry_t  next_entry,
  output tqr_pkg::entry_t  entry
);
  import tqr_pkg::*;

  localparam logic [POS_W:0] ME = (POS_W + 1)'(IDX);

  logic [POS_W:0] idx_ext;
  logic [POS_W:0] idx_minus;
  logic [POS_W:0] idx_plus;
  entry_t         entry_next;

  assign idx_ext   = {1'b0, cmd.index};
  assign idx_minus = idx_ext - 1'b1;
  assign idx_plus  = idx_ext + 1'b1;

  always_comb begin
    entry_next = entry;
    unique case (cmd.act)
      ACT_HOLD: entry_next = entry;
      ACT_LOAD: begin
        if (idx_ext == ME) entry_next = cmd.load;
      end
      ACT_SHIFT: entry_next = next_entry;
      ACT_SWAP_UP: begin
        if (idx_ext == ME) entry_next = prev_entry;
        else if (idx_minus == ME) entry_next = next_entry;
      end
      ACT_SWAP_DOWN: begin
        if (idx_ext == ME) entry_next = next_entry;
        else if (idx_plus == ME) entry_next = prev_entry;
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

FILE: design/ticket_queue_with_reorder.sv
`timescale 1ns / 1ps
`default_nettype none
// A command's result word is registered; it appears in the cycle after acceptance.
// Throughput: one command per cycle unless m_tready stalls; every command is done
// in a single pass over the row of entry cells (append, shift toward the front,
// or neighbor swap). Input is taken while the result register is empty or drained.
// Reset (rst, synchronous, active high) clears the count, last issued id and
// result valid and refuses input; entry contents are left as they are.
module ticket_queue_with_reorder #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // customer_ref[31:0], customer_blank[32], complaint_ref[64:33],
  // complaint_blank[65], position[73:66], zero[79:74]
  input  wire  [79:0] s_tdata,
  // operation[1:0]
  input  wire  [1:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // ticket_number[15:0], served_customer[47:16], served_complaint[79:48],
  // occupancy[84:80], zero[87:85]
  output logic [87:0] m_tdata,
  // status[2:0]
  output logic [2:0]  m_tuser
);
  import tqr_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  logic             accept;
  op_t              op;
  logic [REF_W-1:0] in_customer;
  logic [REF_W-1:0] in_complaint;
  logic             in_cblank;
  logic             in_pblank;
  logic [POS_W-1:0] in_pos;
  logic [POS_W:0]   pos_ext;
  logic [POS_W:0]   count_ext;

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [ID_W-1:0]  last_id;
  logic [ID_W-1:0]  last_id_next;

  status_t          status;
  logic [ID_W-1:0]  number;
  logic [REF_W-1:0] srv_customer;
  logic [REF_W-1:0] srv_complaint;
  cell_cmd_t        cmd;

  entry_t           cells [QUEUE_DEPTH];
  entry_t           prevs [QUEUE_DEPTH];
  entry_t           nexts [QUEUE_DEPTH];

  assign accept       = s_tvalid && s_tready;
  assign s_tready     = !rst && (!m_tvalid || m_tready);
  assign op           = op_t'(s_tuser);
  assign in_customer  = s_tdata[31:0];
  assign in_cblank    = s_tdata[32];
  assign in_complaint = s_tdata[64:33];
  assign in_pblank    = s_tdata[65];
  assign in_pos       = s_tdata[73:66];
  assign pos_ext      = {1'b0, in_pos};
  assign count_ext    = (POS_W + 1)'(count);

  always_comb begin
    status        = ST_OK;
    number        = '0;
    srv_customer  = '0;
    srv_complaint = '0;
    count_next    = count;
    last_id_next  = last_id;
    cmd.act       = ACT_HOLD;
    cmd.index     = in_pos;
    cmd.load.id        = last_id + 1'b1;
    cmd.load.customer  = in_customer;
    cmd.load.complaint = in_complaint;
    unique case (op)
      OP_ADD: begin
        cmd.index = POS_W'(count);
        priority if (in_cblank || in_pblank) begin
          status = ST_EMPTY_TEXT;
        end else if (count == DEPTH_C) begin
          status = ST_FULL;
        end else if (last_id == {ID_W{1'b1}}) begin
          status = ST_IDS_OUT;
        end else begin
          cmd.act      = ACT_LOAD;
          last_id_next = last_id + 1'b1;
          count_next   = count + 1'b1;
          number       = last_id + 1'b1;
        end
      end
      OP_SERVICE: begin
        if (count == '0) begin
          status = ST_QUEUE_EMPTY;
        end else begin
          cmd.act       = ACT_SHIFT;
          count_next    = count - 1'b1;
          number        = cells[0].id;
          srv_customer  = cells[0].customer;
          srv_complaint = cells[0].complaint;
        end
      end
      OP_MOVE_UP: begin
        if (pos_ext >= 9'd1 && pos_ext < count_ext) cmd.act = ACT_SWAP_UP;
        else status = ST_BAD_POS;
      end
      OP_MOVE_DOWN: begin
        if (pos_ext + 1'b1 < count_ext) cmd.act = ACT_SWAP_DOWN;
        else status = ST_BAD_POS;
      end
      default: status = ST_OK;
    endcase
    if (!accept) cmd.act = ACT_HOLD;
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_front
        assign prevs[g] = '0;
      end else begin : g_mid_front
        assign prevs[g] = cells[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_back
        assign nexts[g] = '0;
      end else begin : g_mid_back
        assign nexts[g] = cells[g+1];
      end
      tqr_cell #(.IDX(g)) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .prev_entry (prevs[g]),
        .next_entry (nexts[g]),
        .entry      (cells[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      last_id  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        last_id  <= last_id_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= status;
      m_tdata <= {3'b000, 5'(count_next), srv_complaint, srv_customer, number};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("ticket count beyond queue depth");

  a_empty_service: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_SERVICE && count == '0 |=> m_tuser == ST_QUEUE_EMPTY)
    else $error("service of empty queue not flagged");

  a_add_id: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_ADD && status == ST_OK |=>
      last_id == $past(last_id) + 1'b1 && m_tdata[15:0] == last_id)
    else $error("added ticket id does not follow last issued id");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> count == $past(count))
    else $error("ticket count changed without a command");
`endif

endmodule
`default_nettype wire
